// ===== sv/sk64_pkg.sv =====
// Shared types, constant tables and round functions for the SAFER K-64 pipeline.
package sk64_pkg;

  localparam int MAX_ROUNDS  = 10;
  localparam int NUM_SUBKEYS = 2 * MAX_ROUNDS + 1;
  localparam int RND_W       = 4;
  localparam int SK_IDX_W    = $clog2(NUM_SUBKEYS);

  // configuration register indexes
  localparam logic CFG_KEY    = 1'b0;
  localparam logic CFG_ROUNDS = 1'b1;

  // action codes
  localparam logic ACT_ENC = 1'b0;
  localparam logic ACT_DEC = 1'b1;

  // bytes 0,3,4,7 take XOR in the first mix and exp in the byte layer
  localparam logic [7:0] LANE_A = 8'b1001_1001;

  typedef logic [7:0] tab_t [256];
  typedef logic [63:0] subkey_arr_t [NUM_SUBKEYS];

  typedef struct packed {
    logic        act;
    logic [63:0] blk;
  } item_t;

  function automatic tab_t build_exp();
    tab_t        t;
    int unsigned v;
    v = 1;
    for (int i = 0; i < 256; i++) begin
      t[i] = v[7:0];
      v = (v * 45) % 257;
    end
    return t;
  endfunction

  localparam tab_t EXP_TAB = build_exp();

  function automatic tab_t build_log();
    tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[EXP_TAB[i]] = 8'(i);
    end
    return t;
  endfunction

  localparam tab_t LOG_TAB = build_log();

  // s is always an elaboration-time constant at the call site
  function automatic logic [63:0] make_subkey(logic [63:0] key, int s);
    logic [63:0] k;
    logic [7:0]  b;
    logic [7:0]  idx;
    int          n;
    n = (3 * s) % 8;
    for (int j = 0; j < 8; j++) begin
      b = key[63-8*j -: 8];
      if (n != 0) b = 8'((b << n) | (b >> (8 - n)));
      idx = 8'((9 * (s + 1) + j + 1) % 256);
      if (s != 0) b = b + EXP_TAB[EXP_TAB[idx]];
      k[63-8*j -: 8] = b;
    end
    return k;
  endfunction

  function automatic logic [63:0] mix(logic [63:0] d, logic [63:0] k, logic a_xor,
                                      logic sub);
    logic [63:0] r;
    logic [7:0]  x;
    logic [7:0]  y;
    for (int j = 0; j < 8; j++) begin
      x = d[63-8*j -: 8];
      y = k[63-8*j -: 8];
      if (LANE_A[j] == a_xor) r[63-8*j -: 8] = x ^ y;
      else if (sub)           r[63-8*j -: 8] = x - y;
      else                    r[63-8*j -: 8] = x + y;
    end
    return r;
  endfunction

  function automatic logic [63:0] byte_layer(logic [63:0] d, logic inv);
    logic [63:0] r;
    for (int j = 0; j < 8; j++) begin
      if (LANE_A[j] != inv) r[63-8*j -: 8] = EXP_TAB[d[63-8*j -: 8]];
      else                  r[63-8*j -: 8] = LOG_TAB[d[63-8*j -: 8]];
    end
    return r;
  endfunction

  function automatic logic [63:0] pht(logic [63:0] d);
    logic [7:0] b [8];
    logic [7:0] t [8];
    logic [7:0] x;
    logic [7:0] y;
    logic [63:0] r;
    for (int j = 0; j < 8; j++) b[j] = d[63-8*j -: 8];
    for (int l = 0; l < 3; l++) begin
      for (int j = 0; j < 4; j++) begin
        x = b[2*j];
        y = b[2*j+1];
        b[2*j]   = 8'({x, 1'b0}) + y;
        b[2*j+1] = x + y;
      end
      if (l < 2) begin
        for (int j = 0; j < 4; j++) begin
          t[j]   = b[2*j];
          t[j+4] = b[2*j+1];
        end
        for (int j = 0; j < 8; j++) b[j] = t[j];
      end
    end
    for (int j = 0; j < 8; j++) r[63-8*j -: 8] = b[j];
    return r;
  endfunction

  function automatic logic [63:0] inv_pht(logic [63:0] d);
    logic [7:0] b [8];
    logic [7:0] t [8];
    logic [7:0] x;
    logic [7:0] y;
    logic [63:0] r;
    for (int j = 0; j < 8; j++) b[j] = d[63-8*j -: 8];
    for (int l = 0; l < 3; l++) begin
      for (int j = 0; j < 4; j++) begin
        x = b[2*j];
        y = b[2*j+1];
        b[2*j]   = x - y;
        b[2*j+1] = 8'({y, 1'b0}) - x;
      end
      if (l < 2) begin
        for (int j = 0; j < 4; j++) begin
          t[2*j]   = b[j];
          t[2*j+1] = b[j+4];
        end
        for (int j = 0; j < 8; j++) b[j] = t[j];
      end
    end
    for (int j = 0; j < 8; j++) r[63-8*j -: 8] = b[j];
    return r;
  endfunction

  function automatic logic [63:0] enc_round(logic [63:0] d, logic [63:0] k1,
                                            logic [63:0] k2);
    return pht(mix(byte_layer(mix(d, k1, 1'b1, 1'b0), 1'b0), k2, 1'b0, 1'b0));
  endfunction

  function automatic logic [63:0] dec_round(logic [63:0] d, logic [63:0] k1,
                                            logic [63:0] k2);
    return mix(byte_layer(mix(inv_pht(d), k2, 1'b0, 1'b1), 1'b1), k1, 1'b1, 1'b1);
  endfunction

endpackage

// ===== sv/safer_k64_block_cipher_top.sv =====
// SAFER K-64 encrypt/decrypt engine with a fully unrolled round pipeline.
// Takes one 64-bit request per cycle while the output is not stalled and passes each
// one through an input key-mix stage, ten round stages and an output key-mix stage; the
// latency does not depend on the round count, since unused rounds pass through.
// Each stage holds until the next one frees, so stalls back up without loss.
// Write cipher_key and round_count only while no request is in flight.
module safer_k64_block_cipher_top
  import sk64_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [63:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [0] action, [64:1] block_in, [71:65] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // [63:0] block_out
);

  localparam int NST = MAX_ROUNDS + 1;

  logic [63:0]      cipher_key_r;
  logic [RND_W-1:0] round_count_r;
  logic [RND_W-1:0] rnd;
  subkey_arr_t      sk;
  logic [63:0]      fin_key;

  logic             vld   [NST];
  logic             rdy   [NST];
  item_t            itm   [NST];

  logic             in_vld_r;
  item_t            in_item_r;
  item_t            in_item_nxt;
  logic             out_vld_r;
  logic [63:0]      out_blk_r;
  logic [63:0]      out_blk_nxt;
  logic             in_rdy;
  logic             out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cipher_key_r  <= '0;
      round_count_r <= RND_W'(6);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_KEY:    cipher_key_r  <= cfg_wdata;
        CFG_ROUNDS: round_count_r <= cfg_wdata[RND_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    if (round_count_r == '0)                       rnd = RND_W'(1);
    else if (round_count_r > RND_W'(MAX_ROUNDS))   rnd = RND_W'(MAX_ROUNDS);
    else                                           rnd = round_count_r;
  end

  for (genvar s = 0; s < NUM_SUBKEYS; s++) begin : g_sk
    assign sk[s] = make_subkey(cipher_key_r, s);
  end

  assign fin_key = sk[SK_IDX_W'({rnd, 1'b0})];

  // input stage: decryption opens with the last subkey
  assign in_rdy = !in_vld_r || rdy[0];
  always_comb begin
    in_item_nxt.act = in_tdata[0];
    if (in_tdata[0] == ACT_DEC) begin
      in_item_nxt.blk = mix(in_tdata[64:1], fin_key, 1'b1, 1'b1);
    end else begin
      in_item_nxt.blk = in_tdata[64:1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_rdy) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_tvalid) begin
      in_item_r <= in_item_nxt;
    end
  end

  assign vld[0] = in_vld_r;
  assign itm[0] = in_item_r;

  for (genvar k = 0; k < MAX_ROUNDS; k++) begin : g_rnd
    sk64_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_num (RND_W'(k)),
      .rounds    (rnd),
      .enc_k1    (sk[2*k]),
      .enc_k2    (sk[2*k+1]),
      .dec_k1    (sk[2*(MAX_ROUNDS-1-k)]),
      .dec_k2    (sk[2*(MAX_ROUNDS-1-k)+1]),
      .up_valid  (vld[k]),
      .up_ready  (rdy[k]),
      .up_item   (itm[k]),
      .dn_valid  (vld[k+1]),
      .dn_ready  (rdy[k+1]),
      .dn_item   (itm[k+1])
    );
  end

  // output stage: encryption closes with the last subkey
  assign out_rdy          = !out_vld_r || out_tready;
  assign rdy[MAX_ROUNDS]  = out_rdy;
  assign out_blk_nxt = (itm[MAX_ROUNDS].act == ACT_DEC) ? itm[MAX_ROUNDS].blk
                     : mix(itm[MAX_ROUNDS].blk, fin_key, 1'b1, 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_rdy) begin
      out_vld_r <= vld[MAX_ROUNDS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && vld[MAX_ROUNDS]) begin
      out_blk_r <= out_blk_nxt;
    end
  end

  assign in_tready  = in_rdy;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_blk_r;

`ifndef SYNTHESIS
  a_stall_source : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input back-pressured while output is free");

  a_rounds_range : assert property (@(posedge clk) disable iff (!rst_n)
    (rnd >= RND_W'(1)) && (rnd <= RND_W'(MAX_ROUNDS)))
    else $error("effective round count out of range");

  a_reset_empty : assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result presented right after reset");
`endif

endmodule

// ===== sv/sk64_stage.sv =====
// One pipelined cipher round stage; passes the block through when its round is not used.
module sk64_stage
  import sk64_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [RND_W-1:0] stage_num,
  input  logic [RND_W-1:0] rounds,
  input  logic [63:0]      enc_k1,
  input  logic [63:0]      enc_k2,
  input  logic [63:0]      dec_k1,
  input  logic [63:0]      dec_k2,
  input  logic             up_valid,
  output logic             up_ready,
  input  item_t            up_item,
  output logic             dn_valid,
  input  logic             dn_ready,
  output item_t            dn_item
);

  logic  vld_r;
  item_t item_r;
  item_t item_nxt;
  logic  active;

  always_comb begin
    up_ready = !vld_r || dn_ready;
    // decryption walks the rounds from the top, so it uses the late stages
    if (up_item.act == ACT_DEC) begin
      active = (RND_W'(MAX_ROUNDS - 1) - stage_num) < rounds;
    end else begin
      active = stage_num < rounds;
    end
    item_nxt.act = up_item.act;
    if (!active) begin
      item_nxt.blk = up_item.blk;
    end else if (up_item.act == ACT_DEC) begin
      item_nxt.blk = dec_round(up_item.blk, dec_k1, dec_k2);
    end else begin
      item_nxt.blk = enc_round(up_item.blk, enc_k1, enc_k2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= item_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_item  = item_r;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the SAFER K-64 encrypt/decrypt pipeline.
module tb;
  import sk64_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_addr;
  logic [63:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;

  safer_k64_block_cipher_top dut (.*);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  typedef logic [7:0] byte_arr_t [8];

  logic [7:0]  pw_tab [256];
  logic [7:0]  lg_tab [256];
  logic [63:0] key_reg;
  logic [3:0]  rounds_reg;
  logic [63:0] pending_blocks [$];
  int          err_cnt;
  int          src_idle_pct;
  int          snk_stall_pct;

  function automatic logic [7:0] sched_byte(logic [63:0] key, int s, int j);
    logic [7:0] b;
    int         n;
    b = key[63-8*j -: 8];
    n = (3 * s) % 8;
    if (n != 0) b = 8'((b << n) | (b >> (8 - n)));
    if (s != 0) b = b + pw_tab[pw_tab[8'((9 * (s + 1) + j + 1) % 256)]];
    return b;
  endfunction

  function automatic void key_mix(ref byte_arr_t d, input int s, input bit a_xor,
                                  input bit sub);
    logic [7:0] k;
    bit         lane;
    for (int j = 0; j < 8; j++) begin
      k = sched_byte(key_reg, s, j);
      lane = (j == 0 || j == 3 || j == 4 || j == 7);
      if (lane == a_xor) d[j] = d[j] ^ k;
      else if (sub)      d[j] = d[j] - k;
      else               d[j] = d[j] + k;
    end
  endfunction

  function automatic void sbox_layer(ref byte_arr_t d, input bit inv);
    bit lane;
    for (int j = 0; j < 8; j++) begin
      lane = (j == 0 || j == 3 || j == 4 || j == 7);
      d[j] = (lane != inv) ? pw_tab[d[j]] : lg_tab[d[j]];
    end
  endfunction

  function automatic void mix_levels(ref byte_arr_t d, input bit inv);
    byte_arr_t  t;
    logic [7:0] a;
    logic [7:0] b;
    for (int l = 0; l < 3; l++) begin
      for (int j = 0; j < 4; j++) begin
        a = d[2*j];
        b = d[2*j+1];
        if (!inv) begin
          d[2*j] = 8'(2 * a + b);
          d[2*j+1] = a + b;
        end else begin
          d[2*j] = a - b;
          d[2*j+1] = 8'(2 * b - a);
        end
      end
      if (l < 2) begin
        for (int j = 0; j < 4; j++) begin
          if (!inv) begin
            t[j] = d[2*j];
            t[j+4] = d[2*j+1];
          end else begin
            t[2*j] = d[j];
            t[2*j+1] = d[j+4];
          end
        end
        d = t;
      end
    end
  endfunction

  function automatic logic [63:0] cipher_block(logic act, logic [63:0] blk);
    byte_arr_t   d;
    int          r;
    logic [63:0] res;
    r = int'(rounds_reg);
    if (r < 1) r = 1;
    if (r > MAX_ROUNDS) r = MAX_ROUNDS;
    for (int j = 0; j < 8; j++) d[j] = blk[63-8*j -: 8];
    if (act == ACT_ENC) begin
      for (int i = 0; i < r; i++) begin
        key_mix(d, 2 * i, 1'b1, 1'b0);
        sbox_layer(d, 1'b0);
        key_mix(d, 2 * i + 1, 1'b0, 1'b0);
        mix_levels(d, 1'b0);
      end
      key_mix(d, 2 * r, 1'b1, 1'b0);
    end else begin
      key_mix(d, 2 * r, 1'b1, 1'b1);
      for (int i = r; i > 0; i--) begin
        mix_levels(d, 1'b1);
        key_mix(d, 2 * (i - 1) + 1, 1'b0, 1'b1);
        sbox_layer(d, 1'b1);
        key_mix(d, 2 * (i - 1), 1'b1, 1'b1);
      end
    end
    for (int j = 0; j < 8; j++) res[63-8*j -: 8] = d[j];
    return res;
  endfunction

  // sink side: random stall, check at the rising edge
  always @(negedge clk) begin
    if (rst_n) out_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_blocks.size() == 0) begin
        $error("unexpected result block_out=%h", out_tdata);
        err_cnt++;
      end else begin
        if (out_tdata !== pending_blocks[0]) begin
          $error("block_out expected %h actual %h", pending_blocks[0], out_tdata);
          err_cnt++;
        end
        void'(pending_blocks.pop_front());
      end
    end
  end

  // queue the prediction when the request is taken
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      pending_blocks = {pending_blocks, cipher_block(in_tdata[0], in_tdata[64:1])};
  end

  // leave the request valid on return; the next idle cycle or drain drops it
  task automatic send_block(logic act, logic [63:0] blk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'b0, blk, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_pipe();
    in_tvalid <= 1'b0;
    while (pending_blocks.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  // leaves the write enable high; the caller drops it after the last write
  task automatic write_reg(logic addr, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= val;
    @(negedge clk);
    if (addr == CFG_KEY) key_reg = val;
    else                 rounds_reg = val[3:0];
  endtask

  typedef struct {
    logic        act;
    logic [63:0] blk;
    logic        known;
    logic [63:0] want;
  } vec_t;

  vec_t        dir_tab [] = '{
    '{ACT_ENC, 64'h0102030405060708, 1'b0, 64'h0},
    '{ACT_ENC, 64'h0000000000000000, 1'b0, 64'h0},
    '{ACT_ENC, 64'hFFFFFFFFFFFFFFFF, 1'b0, 64'h0},
    '{ACT_DEC, 64'h0000000000000000, 1'b0, 64'h0},
    '{ACT_DEC, 64'hFFFFFFFFFFFFFFFF, 1'b0, 64'h0},
    '{ACT_ENC, 64'h8000000000000001, 1'b0, 64'h0},
    '{ACT_DEC, 64'h5555AAAA5555AAAA, 1'b0, 64'h0},
    '{ACT_ENC, 64'hAAAA5555AAAA5555, 1'b0, 64'h0}
  };
  logic [63:0] key_set [6] = '{64'h0, 64'hFFFFFFFFFFFFFFFF, 64'h0807060504030201,
                               64'h0102030405060708, 64'h8000000000000001, 64'h0};
  logic [3:0]  rnd_set [6] = '{4'd6, 4'd10, 4'd1, 4'd6, 4'd0, 4'd15};
  int          idle_src [4] = '{0, 79, 0, 27};
  int          idle_snk [4] = '{0, 0, 79, 27};

  initial begin
    logic [63:0] blk;
    logic [63:0] ct;
    for (int i = 0; i < 256; i++) begin
      pw_tab[i] = 8'h0;
    end
    begin
      int v;
      v = 1;
      for (int i = 0; i < 256; i++) begin
        pw_tab[i] = v[7:0];
        lg_tab[v[7:0]] = i[7:0];
        v = (v * 45) % 257;
      end
    end
    err_cnt = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    key_reg = 64'h0;
    rounds_reg = 4'd6;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = CFG_KEY;
    cfg_wdata = 64'h0;
    in_tvalid = 1'b0;
    in_tdata = 72'h0;
    out_tready = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset key and rounds: directed rows, checked against the predictor
    for (int i = 0; i < dir_tab.size(); i++) begin
      if (dir_tab[i].known && cipher_block(dir_tab[i].act, dir_tab[i].blk) !== dir_tab[i].want) begin
        $error("block_out expected %h actual %h", dir_tab[i].want,
               cipher_block(dir_tab[i].act, dir_tab[i].blk));
        err_cnt++;
      end
      send_block(dir_tab[i].act, dir_tab[i].blk);
    end
    drain_pipe();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_KEY, (ph == 5) ? {$urandom, $urandom} : key_set[ph]);
      write_reg(CFG_ROUNDS, 64'(rnd_set[ph]));
      cfg_we <= 1'b0;
      for (int n = 0; n < 175; n++) begin
        src_idle_pct = idle_src[(n / 20) % 4];
        snk_stall_pct = idle_snk[(n / 20) % 4];
        blk = {$urandom, $urandom};
        if (n % 7 == 0) blk = $urandom_range(1) ? 64'hFFFFFFFFFFFFFFFF : 64'h0;
        if (n % 5 == 0) begin
          // round trip: decrypt the encrypted block
          ct = cipher_block(ACT_ENC, blk);
          send_block(ACT_ENC, blk);
          send_block(ACT_DEC, ct);
        end else begin
          send_block(1'($urandom_range(1)), blk);
        end
      end
      src_idle_pct = 0;
      snk_stall_pct = 0;
      drain_pipe();
    end
    if (err_cnt == 0) $display("DONE: 0 errors");
    else              $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
sv/sk64_pkg.sv
sv/sk64_stage.sv
sv/safer_k64_block_cipher_top.sv
tb/tb.sv
